### rtl/core/u8u16_pkg.sv
package u8u16_pkg;

	// lead byte ranges and second-byte limits
	localparam logic [7:0] LeadTwoLo   = 8'hc2;
	localparam logic [7:0] LeadTwoHi   = 8'hdf;
	localparam logic [7:0] LeadThreeLo = 8'he0;
	localparam logic [7:0] LeadE0      = 8'he0;
	localparam logic [7:0] LeadEd      = 8'hed;
	localparam logic [7:0] LeadF0      = 8'hf0;
	localparam logic [7:0] LeadF4      = 8'hf4;
	localparam logic [7:0] LeadFourLo  = 8'hf0;
	localparam logic [7:0] TrailMask   = 8'hc0;
	localparam logic [7:0] TrailBits   = 8'h80;

	// surrogate pair constants
	localparam logic [20:0] SuppBase = 21'h10000;
	localparam logic [15:0] HighSurr = 16'hd800;
	localparam logic [15:0] LowSurr  = 16'hdc00;

	localparam int unsigned MaxUnits = 4;

	// one result word
	typedef struct packed {
		logic [15:0] code_unit;
		logic        raw_fallback;
		logic        last_unit;
	} unit_t;

	// all results caused by one byte
	typedef struct packed {
		unit_t [MaxUnits-1:0] units;
		logic [2:0]           count;
	} unit_set_t;

	// outcome of decoding at one buffer position
	typedef struct packed {
		logic        stop;
		logic        pair;
		logic        raw;
		logic [15:0] unit_a;
		logic [15:0] unit_b;
		logic [2:0]  adv;
	} step_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0) len = 3'd1;
		else if (b >= LeadTwoLo && b <= LeadTwoHi) len = 3'd2;
		else if (b >= LeadThreeLo && b < LeadFourLo) len = 3'd3;
		else if (b >= LeadFourLo && b <= LeadF4) len = 3'd4;
		else len = 3'd0;
		return len;
	endfunction

	function automatic logic is_trail(input logic [7:0] b);
		return (b & TrailMask) == TrailBits;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		if (lead == LeadE0) ok = (b >= 8'ha0) && (b <= 8'hbf);
		else if (lead == LeadEd) ok = (b >= 8'h80) && (b <= 8'h9f);
		else if (lead == LeadF0) ok = (b >= 8'h90) && (b <= 8'hbf);
		else if (lead == LeadF4) ok = (b >= 8'h80) && (b <= 8'h8f);
		else ok = is_trail(b);
		return ok;
	endfunction

	// decode the sequence starting at position p of a four-byte buffer holding n bytes
	function automatic step_t pos_decode(input logic [3:0][7:0] bufv, input logic [1:0] p,
			input logic [2:0] n, input logic eos);
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [2:0]  len;
		logic [2:0]  avail;
		logic        ok;
		logic [20:0] cp;
		logic [20:0] sd;
		step_t       r;
		b0    = bufv[p];
		b1    = bufv[2'(p + 2'd1)];
		b2    = bufv[2'(p + 2'd2)];
		b3    = bufv[2'(p + 2'd3)];
		len   = lead_len(b0);
		avail = n - {1'b0, p};
		r     = '0;
		ok    = 1'b1;
		if (len >= 3'd2 && avail >= 3'd2 && !second_ok(b0, b1)) ok = 1'b0;
		if (len >= 3'd3 && avail >= 3'd3 && !is_trail(b2)) ok = 1'b0;
		if (len >= 3'd4 && avail >= 3'd4 && !is_trail(b3)) ok = 1'b0;
		unique case (len)
			3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
			3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
		endcase
		sd = cp - SuppBase;
		priority if (len == 3'd1) begin
			r.unit_a = {8'd0, b0};
			r.adv    = 3'd1;
		end else if (len == 3'd0 || !ok) begin
			r.unit_a = {8'd0, b0};
			r.raw    = 1'b1;
			r.adv    = 3'd1;
		end else if (avail < len) begin
			if (eos) begin
				r.unit_a = {8'd0, b0};
				r.raw    = 1'b1;
				r.adv    = 3'd1;
			end else begin
				r.stop = 1'b1;
			end
		end else if (len == 3'd4) begin
			r.pair   = 1'b1;
			r.unit_a = HighSurr + {6'd0, sd[19:10]};
			r.unit_b = LowSurr + {6'd0, sd[9:0]};
			r.adv    = 3'd4;
		end else begin
			r.unit_a = cp[15:0];
			r.adv    = len;
		end
		return r;
	endfunction

endpackage

### rtl/core/u8u16_decode.sv
module u8u16_decode (
	input  logic [2:0][7:0]        pend_bytes,
	input  logic [1:0]             pend_count,
	input  logic [7:0]             byte_in,
	input  logic                   eos,
	output u8u16_pkg::unit_set_t   result,
	output logic [2:0][7:0]        next_bytes,
	output logic [1:0]             next_count
);

	logic [3:0][7:0]           bufv;
	logic [2:0]                n;
	u8u16_pkg::step_t [3:0]    st;
	u8u16_pkg::step_t          sel;
	logic [2:0]                pos;
	logic [2:0]                cnt;
	logic [2:0]                idx;
	logic                      done;

	// pending bytes followed by the new byte
	always_comb begin
		bufv = '0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < pend_count) bufv[i] = pend_bytes[i];
		end
		bufv[pend_count] = byte_in;
		n = {1'b0, pend_count} + 3'd1;
	end

	// decode at every start position in parallel
	always_comb begin
		for (int j = 0; j < 4; j++) st[j] = u8u16_pkg::pos_decode(bufv, 2'(j), n, eos);
	end

	// walk the buffer, collecting units into result slots
	always_comb begin
		result = '0;
		pos    = 3'd0;
		cnt    = 3'd0;
		done   = 1'b0;
		sel    = '0;
		for (int s = 0; s < 4; s++) begin
			sel = st[pos[1:0]];
			if (!done && pos < n && !sel.stop) begin
				result.units[cnt[1:0]].code_unit    = sel.unit_a;
				result.units[cnt[1:0]].raw_fallback = sel.raw;
				cnt = cnt + 3'd1;
				if (sel.pair) begin
					result.units[cnt[1:0]].code_unit = sel.unit_b;
					cnt = cnt + 3'd1;
				end
				pos = pos + sel.adv;
			end else begin
				done = 1'b1;
			end
		end
		if (eos && cnt != 3'd0) result.units[2'(cnt - 3'd1)].last_unit = 1'b1;
		result.count = cnt;
	end

	// unfinished tail becomes the new pending bytes
	always_comb begin
		idx = 3'd0;
		for (int i = 0; i < 3; i++) begin
			idx = pos + 3'(i);
			next_bytes[i] = (idx < n) ? bufv[idx[1:0]] : 8'd0;
		end
		next_count = 2'(n - pos);
	end

endmodule

### rtl/core/u8u16_outq.sv
module u8u16_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  u8u16_pkg::unit_set_t  result,
	output logic                  can_load,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // code_unit
	output logic                  m_tuser,   // raw_fallback
	output logic                  m_tlast
);

	u8u16_pkg::unit_t [u8u16_pkg::MaxUnits-1:0] units_q;
	logic [2:0]                                 left_q;
	logic [1:0]                                 rd_q;

	assign m_tvalid = left_q != 3'd0;
	assign can_load = (left_q == 3'd0) || (left_q == 3'd1 && m_tready);
	assign m_tdata  = units_q[rd_q].code_unit;
	assign m_tuser  = units_q[rd_q].raw_fallback;
	assign m_tlast  = units_q[rd_q].last_unit;

	// result words, no reset needed
	always_ff @(posedge clk) begin
		if (load && can_load) units_q <= result.units;
	end

	// drain one word per cycle while m_tready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
			rd_q   <= 2'd0;
		end else if (load && can_load) begin
			left_q <= result.count;
			rd_q   <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			left_q <= left_q - 3'd1;
			rd_q   <= rd_q + 2'd1;
		end
	end

endmodule

### rtl/core/utf8_to_utf16_transcoder_top.sv
// a byte is held in the input stage register, then decoded combinationally and loaded into
// the result register, from which its first code unit is offered
// throughput: one byte per cycle while each byte yields at most one code unit and m_tready is high;
// a byte yielding more units (up to four) holds the input until the result register has drained
// all but the last of them, one word per cycle while m_tready is high
// reset: arst_n clears the input valid flag, the result word count and the pending bytes
module utf8_to_utf16_transcoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // code_unit
	output logic        m_tuser,   // raw_fallback
	output logic        m_tlast
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eos_s1;
	logic [2:0][7:0]       pend_q;
	logic [1:0]            pcnt_q;
	logic [2:0][7:0]       next_bytes;
	logic [1:0]            next_count;
	u8u16_pkg::unit_set_t  result;
	logic                  can_load;
	logic                  adv;

	assign adv      = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	// bytes of an unfinished sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= 2'd0;
		end else if (adv) begin
			pend_q <= next_bytes;
			pcnt_q <= next_count;
		end
	end

	u8u16_decode u_decode (
		.pend_bytes (pend_q),
		.pend_count (pcnt_q),
		.byte_in    (byte_s1),
		.eos        (eos_s1),
		.result     (result),
		.next_bytes (next_bytes),
		.next_count (next_count)
	);

	u8u16_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.result   (result),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
